FILE: sv/p7pu_pkg.sv
// Shared constants, state and command types for the padding stream block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package p7pu_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_CHECK,
        S_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_PAD,
        EM_FAIL,
        EM_EMPTY,
        EM_KEEP
    } t_emit;

    typedef struct packed {
        logic             take;
        t_emit            emit;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic out_free;
        logic pad_ok;
        logic match;
        logic pad_done;
        logic keep_zero;
        logic keep_done;
        logic pad_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/p7pu_dp.sv
// Datapath: mode register, message counters, hold window and result register.
// Depends on p7pu_pkg; driven by p7pu_ctrl through t_cmd, reports through t_sts.
`default_nettype none

module p7pu_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic [p7pu_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_has_data,
    input  wire logic                          i_msg_end,
    input  wire logic                          i_res_stall,
    input  wire p7pu_pkg::t_cmd                i_cmd,
    output p7pu_pkg::t_sts                     o_sts,
    output logic                               o_res_valid,
    output logic [p7pu_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_out_valid,
    output logic                               o_out_last,
    output logic                               o_status
);

    logic                          r_mode;
    logic [p7pu_pkg::CNT_W-1:0]    r_count, n_count;
    logic [p7pu_pkg::IDX_W-1:0]    r_len, n_len;
    logic                          r_seen, n_seen;
    logic                          r_shape_ok, n_shape_ok;
    logic [p7pu_pkg::BYTE_W-1:0]   r_pad_val, n_pad_val;
    logic [p7pu_pkg::BYTE_W-1:0]   r_win [p7pu_pkg::BLOCK_BYTES];

    logic                          r_ov, n_ov;
    logic [p7pu_pkg::BYTE_W-1:0]   r_ob, n_ob;
    logic                          r_ovd, n_ovd;
    logic                          r_ol, n_ol;
    logic                          r_os, n_os;

    logic                          full;
    logic [p7pu_pkg::IDX_W-1:0]    len_inc;
    logic [p7pu_pkg::IDX_W-1:0]    rd_addr;
    logic [p7pu_pkg::BYTE_W-1:0]   rd_byte;
    logic [p7pu_pkg::BYTE_W-1:0]   pad;
    logic [p7pu_pkg::BYTE_W-1:0]   idx_p1;
    logic [p7pu_pkg::BYTE_W-1:0]   blk;
    logic                          out_free;

    assign blk      = p7pu_pkg::BYTE_W'(p7pu_pkg::BLOCK_BYTES);
    assign full     = (r_count == p7pu_pkg::CNT_W'(p7pu_pkg::BLOCK_BYTES));
    assign len_inc  = (r_len == p7pu_pkg::IDX_W'(p7pu_pkg::BLOCK_BYTES - 1)) ?
                      '0 : r_len + 1'b1;
    assign rd_addr  = (i_cmd.emit == p7pu_pkg::EM_KEEP) ? i_cmd.idx :
                      p7pu_pkg::IDX_W'(p7pu_pkg::BLOCK_BYTES - 1) - i_cmd.idx;
    assign rd_byte  = r_win[rd_addr];
    assign pad      = r_win[p7pu_pkg::BLOCK_BYTES-1];
    assign idx_p1   = p7pu_pkg::BYTE_W'(i_cmd.idx) + 1'b1;
    assign out_free = !r_ov || !i_res_stall;

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.out_free  = out_free;
        o_sts.pad_ok    = r_shape_ok && (pad != '0) && (pad <= blk);
        o_sts.match     = (rd_byte == pad);
        o_sts.pad_done  = (idx_p1 == pad);
        o_sts.keep_zero = (pad == blk);
        o_sts.keep_done = (idx_p1 == blk - pad);
        o_sts.pad_last  = (idx_p1 == r_pad_val);
    end

    // message counters
    always_comb begin
        n_count    = r_count;
        n_len      = r_len;
        n_seen     = r_seen;
        n_shape_ok = r_shape_ok;
        n_pad_val  = r_pad_val;
        if (i_cfg_we) begin
            n_count = '0;
            n_len   = '0;
            n_seen  = 1'b0;
        end else if (i_cmd.take) begin
            if (i_has_data) begin
                n_len  = len_inc;
                n_seen = 1'b1;
                if (r_mode && !full) begin
                    n_count = r_count + 1'b1;
                end
            end
            if (i_msg_end) begin
                n_shape_ok = n_seen && (n_len == '0) &&
                             (n_count == p7pu_pkg::CNT_W'(p7pu_pkg::BLOCK_BYTES));
                n_pad_val  = blk - p7pu_pkg::BYTE_W'(n_len);
                n_count    = '0;
                n_len      = '0;
                n_seen     = 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        n_ov  = r_ov && i_res_stall;
        n_ob  = r_ob;
        n_ovd = r_ovd;
        n_ol  = r_ol;
        n_os  = r_os;
        if (i_cmd.take && i_has_data && (!r_mode || full)) begin
            n_ov  = 1'b1;
            n_ob  = r_mode ? r_win[0] : i_data_byte;
            n_ovd = 1'b1;
            n_ol  = 1'b0;
            n_os  = 1'b0;
        end else begin
            case (i_cmd.emit)
                p7pu_pkg::EM_PAD: begin
                    n_ov  = 1'b1;
                    n_ob  = r_pad_val;
                    n_ovd = 1'b1;
                    n_ol  = o_sts.pad_last;
                    n_os  = 1'b0;
                end
                p7pu_pkg::EM_FAIL: begin
                    n_ov  = 1'b1;
                    n_ob  = '0;
                    n_ovd = 1'b0;
                    n_ol  = 1'b1;
                    n_os  = 1'b1;
                end
                p7pu_pkg::EM_EMPTY: begin
                    n_ov  = 1'b1;
                    n_ob  = '0;
                    n_ovd = 1'b0;
                    n_ol  = 1'b1;
                    n_os  = 1'b0;
                end
                p7pu_pkg::EM_KEEP: begin
                    n_ov  = 1'b1;
                    n_ob  = rd_byte;
                    n_ovd = 1'b1;
                    n_ol  = o_sts.keep_done;
                    n_os  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= '0;
            r_len   <= '0;
            r_seen  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_count <= n_count;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shape_ok <= n_shape_ok;
        r_pad_val  <= n_pad_val;
        r_ob       <= n_ob;
        r_ovd      <= n_ovd;
        r_ol       <= n_ol;
        r_os       <= n_os;
    end

    // shift the newest byte in at the top, oldest falls out of entry 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_has_data && r_mode) begin
            for (int k = 0; k < p7pu_pkg::BLOCK_BYTES - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[p7pu_pkg::BLOCK_BYTES-1] <= i_data_byte;
        end
    end

    assign o_res_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_valid = r_ovd;
    assign o_out_last  = r_ol;
    assign o_status    = r_os;

endmodule

`default_nettype wire

FILE: sv/p7pu_ctrl.sv
// Controller: state machine that sequences pass-through, pad emission,
// pad check and drain. Depends on p7pu_pkg; drives p7pu_dp through t_cmd.
`default_nettype none

module p7pu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_msg_end,
    input  wire p7pu_pkg::t_sts   i_sts,
    output logic                  o_in_stall,
    output p7pu_pkg::t_cmd        o_cmd
);

    p7pu_pkg::t_state             r_state, n_state;
    logic [p7pu_pkg::IDX_W-1:0]   r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= p7pu_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_in_stall = 1'b1;
        o_cmd.take = 1'b0;
        o_cmd.emit = p7pu_pkg::EM_NONE;
        o_cmd.idx  = r_idx;
        case (r_state)
            p7pu_pkg::S_IDLE: begin
                o_in_stall = !i_sts.out_free;
                o_cmd.take = i_in_valid && i_sts.out_free;
                if (o_cmd.take && i_msg_end) begin
                    n_idx   = '0;
                    n_state = i_sts.mode ? p7pu_pkg::S_CHECK : p7pu_pkg::S_PAD;
                end
            end
            p7pu_pkg::S_PAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = p7pu_pkg::EM_PAD;
                    if (i_sts.pad_last) begin
                        n_state = p7pu_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            p7pu_pkg::S_CHECK: begin
                if (!i_sts.pad_ok || !i_sts.match) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = p7pu_pkg::EM_FAIL;
                        n_state    = p7pu_pkg::S_IDLE;
                    end
                end else if (i_sts.pad_done) begin
                    if (i_sts.keep_zero) begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = p7pu_pkg::EM_EMPTY;
                            n_state    = p7pu_pkg::S_IDLE;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = p7pu_pkg::S_DRAIN;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            p7pu_pkg::S_DRAIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = p7pu_pkg::EM_KEEP;
                    if (i_sts.keep_done) begin
                        n_state = p7pu_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = p7pu_pkg::S_IDLE;
            end
        endcase
    end

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit != p7pu_pkg::EM_NONE) |-> i_sts.out_free)
        else $error("result issued while result register is blocked");

    a_end_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_msg_end) |=> (r_state != p7pu_pkg::S_IDLE))
        else $error("message end did not start the end sequence");

    a_drain_pad_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == p7pu_pkg::S_DRAIN) |-> (i_sts.pad_ok && !i_sts.keep_zero))
        else $error("drain entered without a valid pad");

endmodule

`default_nettype wire

FILE: sv/pkcs7_pad_unpad_stream.sv
// Byte-stream padder and unpadder for 16-byte blocks (PKCS#7 style).
// Top level; depends on p7pu_pkg, p7pu_ctrl and p7pu_dp.
// Rate: one byte per cycle while a message streams and the result register
// is free. At a message end the input stalls while the end sequence runs
// from the single result register: in pad mode it emits the N pad bytes
// (1..16); in unpad mode it checks the P pad bytes one per cycle through the
// window's one read port (P = pad value, 1..16; fewer when a pad byte
// mismatches, only one when the length or the pad value is wrong), then
// drains the 16 - P kept bytes. Output stalls hold every result-issuing step.
// Writing the mode aborts the current message; write it only while idle.
`default_nettype none

module pkcs7_pad_unpad_stream (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [p7pu_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_has_data,
    input  wire logic                          i_msg_end,
    output logic                               o_res_valid,
    input  wire logic                          i_res_stall,
    output logic [p7pu_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_out_valid,
    output logic                               o_out_last,
    output logic                               o_status
);

    p7pu_pkg::t_cmd cmd;
    p7pu_pkg::t_sts sts;

    p7pu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_msg_end  (i_msg_end),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    p7pu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_data_byte),
        .i_has_data  (i_has_data),
        .i_msg_end   (i_msg_end),
        .i_res_stall (i_res_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire
